// ===== hdl/pwlgm_pkg.sv =====
// ============================================================================
// Piecewise-linear gauge map package
// Shared widths, codes, register defaults and the controller state type.
// ============================================================================
package pwlgm_pkg;

    // Payload widths.
    localparam int IN_W    = 24;   // signed readings, 8 fraction bits
    localparam int OUT_W   = 16;   // unsigned volts, 12 fraction bits
    localparam int PIDX_W  = 4;    // breakpoint position of a load beat
    localparam int CNT_W   = 5;    // breakpoint count registers

    // Divider: the quotient never exceeds the output span, so one step per
    // output bit is enough.
    localparam int DIV_STEPS = OUT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int DATA_W       = 32;
    localparam int PADDR_W      = 3;
    localparam int REG_ADDR_LSB = 2;

    localparam logic REG_T0_POINTS = 1'b0;
    localparam logic REG_T1_POINTS = 1'b1;

    localparam logic [CNT_W-1:0] T0_POINTS_RST = 5'd15;
    localparam logic [CNT_W-1:0] T1_POINTS_RST = 5'd8;

    // Beat codes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ===== hdl/pwlgm_in_if.sv =====
// ============================================================================
// Piecewise-linear gauge map input channel
// Valid/ready channel carrying one load or lookup beat.
// ============================================================================
interface pwlgm_in_if;
    import pwlgm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic                     table_select;
    logic [PIDX_W-1:0]        point_index;
    logic signed [IN_W-1:0]   point_input;
    logic [OUT_W-1:0]         point_output;
    logic signed [IN_W-1:0]   sample_value;

    modport source (
        output valid, mode, table_select, point_index, point_input, point_output,
               sample_value,
        input  ready
    );

    modport sink (
        input  valid, mode, table_select, point_index, point_input, point_output,
               sample_value,
        output ready
    );

endinterface

// ===== hdl/pwlgm_out_if.sv =====
// ============================================================================
// Piecewise-linear gauge map result channel
// Valid/ready channel carrying one interpolated gauge voltage.
// ============================================================================
interface pwlgm_out_if;
    import pwlgm_pkg::*;

    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  gauge_volts;

    modport source (
        output valid, gauge_volts,
        input  ready
    );

    modport sink (
        input  valid, gauge_volts,
        output ready
    );

endinterface

// ===== hdl/piecewise_linear_gauge_map.sv =====
// ============================================================================
// Piecewise-linear gauge map
// Maps a sensor reading to a gauge drive voltage through one of up to two
// calibration tables of ascending breakpoints held in a synchronous memory.
// ============================================================================
//
//  Channel    Direction  Handshake              Beat contents
//  ---------  ---------  ---------------------  -------------------------------
//  i_in       in         valid/ready            load or lookup request
//  o_out      out        valid/ready            gauge_volts, one per lookup
//  APB        in/out     psel/penable, pready   breakpoint counts per table
//
//  A load beat is written into the breakpoint memory in the cycle it is
//  accepted, and the next beat can be taken in the following cycle.
//  A lookup walks the table one breakpoint per cycle through the memory read
//  port until a breakpoint closes the segment or the last one is read, then,
//  when it interpolates, runs one multiply and 16 divide steps; the next beat
//  is taken only once the result has left the done state.
//  Reset (synchronous, active low) idles the controller, empties the output
//  register and loads the default counts; the memory itself is not cleared.
//  A stalled output holds its result while the next beat is already accepted;
//  a second finished result waits in the done state until the first is taken.
//
module piecewise_linear_gauge_map #(
    parameter int MAX_POINTS = 16,
    parameter int NUM_TABLES = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pwlgm_pkg::PADDR_W-1:0]    paddr,
    input  logic [pwlgm_pkg::DATA_W-1:0]     pwdata,
    output logic [pwlgm_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,
    pwlgm_in_if.sink                         i_in,
    pwlgm_out_if.source                      o_out
);
    import pwlgm_pkg::*;

    // One memory holds every table back to back; each entry packs the
    // breakpoint input above its output.
    localparam int DEPTH  = NUM_TABLES * MAX_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PI_W   = $clog2(MAX_POINTS);
    localparam int MEM_W  = IN_W + OUT_W;

    logic [MEM_W-1:0] r_mem [DEPTH];
    logic [MEM_W-1:0] r_rd;

    // Configuration registers.
    logic [CNT_W-1:0] r_t0_points;
    logic [CNT_W-1:0] r_t1_points;

    // Controller and working registers.
    t_state                 r_state, n_state;
    logic signed [IN_W-1:0] r_x;
    logic [ADDR_W-1:0]      r_base;
    logic [PI_W-1:0]        r_idx;
    logic [PI_W-1:0]        r_last;
    logic signed [IN_W-1:0] r_x0;
    logic [OUT_W-1:0]       r_y0;
    logic [OUT_W-1:0]       r_res;
    logic                   r_interp;
    logic [IN_W-1:0]        r_dx;
    logic [OUT_W-1:0]       r_dy_abs;
    logic                   r_neg;
    logic [IN_W-1:0]        r_span;
    logic [IN_W-1:0]        r_rem;
    logic [OUT_W-1:0]       r_quo;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_volts;

    // Accept-side decode.
    logic                   table_sat;
    logic [CNT_W-1:0]       acc_count;
    logic [PI_W-1:0]        acc_last;
    logic [ADDR_W-1:0]      acc_base;
    logic                   load_ok;
    logic [ADDR_W-1:0]      wr_addr;

    // Walk-side decode.
    logic signed [IN_W-1:0] rd_in;
    logic [OUT_W-1:0]       rd_out;
    logic                   hit;
    logic                   at_last;
    logic signed [IN_W:0]   span;
    logic [IN_W:0]          dx_full;
    logic signed [OUT_W:0]  dy;
    logic [OUT_W:0]         dy_mag;
    logic                   use_div;

    // Divider step and result assembly.
    logic [IN_W:0]          div_trial;
    logic                   div_ge;
    logic [IN_W:0]          div_diff;
    logic [IN_W+OUT_W-1:0]  product;
    logic [OUT_W-1:0]       final_volts;

    // Controls from the state machine.
    logic                   in_ready;
    logic                   mem_we;
    logic                   out_load;
    logic [ADDR_W-1:0]      rd_addr;

    function automatic logic signed [IN_W-1:0] rd_in_of(input logic [MEM_W-1:0] w);
        rd_in_of = w[MEM_W-1:OUT_W];
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. Only the register-select bit of the address is
    // decoded, so every write lands in one of the two counts.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb begin
        case (paddr[REG_ADDR_LSB])
            REG_T0_POINTS: prdata = DATA_W'(r_t0_points);
            REG_T1_POINTS: prdata = DATA_W'(r_t1_points);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_points <= T0_POINTS_RST;
            r_t1_points <= T1_POINTS_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[REG_ADDR_LSB])
                REG_T0_POINTS: r_t0_points <= pwdata[CNT_W-1:0];
                REG_T1_POINTS: r_t1_points <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept-side decode. A table select past the last table saturates to
    // it; table zero has its own count and table one has the second. A
    // count of zero acts as one and a count above the table size acts as
    // the table size.
    // ------------------------------------------------------------------
    assign table_sat = (NUM_TABLES > 1) ? i_in.table_select : 1'b0;
    assign acc_base  = table_sat ? ADDR_W'(MAX_POINTS) : '0;
    assign acc_count = table_sat ? r_t1_points : r_t0_points;

    always_comb begin
        if (acc_count == '0) begin
            acc_last = '0;
        end else if (int'(acc_count) > MAX_POINTS) begin
            acc_last = PI_W'(MAX_POINTS - 1);
        end else begin
            acc_last = PI_W'(acc_count - CNT_W'(1));
        end
    end

    // A load beat aimed past the end of its table is dropped.
    assign load_ok = int'(i_in.point_index) < MAX_POINTS;
    assign wr_addr = acc_base + ADDR_W'(i_in.point_index);

    // ------------------------------------------------------------------
    // Walk-side decode. The read data is the breakpoint at r_idx; the one
    // before it sits in r_x0/r_y0. The first breakpoint not below the
    // sample closes the segment.
    // ------------------------------------------------------------------
    assign rd_in   = rd_in_of(r_rd);
    assign rd_out  = r_rd[OUT_W-1:0];
    assign hit     = r_x <= rd_in;
    assign at_last = r_idx == r_last;
    assign span    = (IN_W+1)'(rd_in) - (IN_W+1)'(r_x0);
    assign dx_full = (IN_W+1)'(r_x) - (IN_W+1)'(r_x0);
    assign dy      = $signed({1'b0, rd_out}) - $signed({1'b0, r_y0});
    assign dy_mag  = dy[OUT_W] ? (OUT_W+1)'(-dy) : (OUT_W+1)'(dy);
    assign use_div = (r_idx != '0) && (span > 0);

    // Restoring divide step: the remainder always stays below the span.
    assign div_trial = {r_rem, r_quo[OUT_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_span};
    assign div_diff  = div_trial - {1'b0, r_span};

    assign product = r_dx * r_dy_abs;

    // Truncation toward zero comes from dividing magnitudes.
    assign final_volts = !r_interp ? r_res :
                         (r_neg ? r_y0 - r_quo : r_y0 + r_quo);

    // ------------------------------------------------------------------
    // State machine.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        mem_we   = 1'b0;
        out_load = 1'b0;
        rd_addr  = r_base + ADDR_W'(r_idx);
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                rd_addr  = acc_base;
                if (i_in.valid) begin
                    if (i_in.mode == MODE_LOOKUP) begin
                        n_state = S_WALK;
                    end else begin
                        mem_we = load_ok;
                    end
                end
            end
            S_WALK: begin
                // Fetch the next breakpoint speculatively.
                if (!at_last) begin
                    rd_addr = r_base + ADDR_W'(r_idx) + ADDR_W'(1);
                end
                if (hit) begin
                    n_state = use_div ? S_MUL : S_DONE;
                end else if (at_last) begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready = in_ready;

    // ------------------------------------------------------------------
    // Breakpoint memory: one write port for load beats, one registered
    // read port for the walk. Only one beat is in flight, so a read can meet a
    // write of the same entry only during a load beat, whose read is unused.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[wr_addr] <= {i_in.point_input, i_in.point_output};
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_x    <= i_in.sample_value;
                    r_base <= acc_base;
                    r_last <= acc_last;
                    r_idx  <= '0;
                end
            end
            S_WALK: begin
                r_res    <= rd_out;
                r_interp <= hit && use_div;
                r_dx     <= dx_full[IN_W-1:0];
                r_dy_abs <= dy_mag[OUT_W-1:0];
                r_neg    <= dy[OUT_W];
                r_span   <= span[IN_W-1:0];
                if (!hit && !at_last) begin
                    r_x0  <= rd_in;
                    r_y0  <= rd_out;
                    r_idx <= r_idx + PI_W'(1);
                end
            end
            S_MUL: begin
                // The product stays below span * 2^16, so its upper part
                // seeds the remainder and its lower part the dividend bits.
                r_rem <= product[IN_W+OUT_W-1:OUT_W];
                r_quo <= product[OUT_W-1:0];
                r_cnt <= '1;
            end
            S_DIV: begin
                r_rem <= div_ge ? div_diff[IN_W-1:0] : div_trial[IN_W-1:0];
                r_quo <= {r_quo[OUT_W-2:0], div_ge};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_volts <= final_volts;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.gauge_volts = r_out_volts;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_last))
        else $error("breakpoint walk ran past the last breakpoint in use");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_span))
        else $error("divider remainder not below the span");

    a_lookup_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready && i_in.mode == MODE_LOOKUP) |=> (r_state == S_WALK))
        else $error("accepted lookup did not start a walk");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready && i_in.mode == MODE_LOAD) |=> (r_state == S_IDLE))
        else $error("load beat left the idle state");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not moved into the output register");

endmodule
